>>> sv/swlp_pkg.sv
// ----------------------------------------------------------------------------
// swlp_pkg
// Shared constants and types for the sliding-window linear predictor.
// ----------------------------------------------------------------------------
`default_nettype none
package swlp_pkg;
   localparam int MaxSlots   = 16;
   localparam int SlotW      = $clog2(MaxSlots);
   localparam int CountW     = $clog2(MaxSlots + 1);
   localparam int WinW       = 5;
   localparam int SampleW    = 24;
   localparam int TimeW      = 32;
   localparam int WideW      = 128;
   localparam logic [WinW-1:0] WinReset = 5'd5;

   localparam logic [1:0] STATUS_FIT    = 2'd0;
   localparam logic [1:0] STATUS_SINGLE = 2'd1;
   localparam logic [1:0] STATUS_MEAN   = 2'd2;

   // Ring memory entry: sample and its timestamp.
   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      logic [TimeW-1:0]          stamp;
   } slot_type;

   // Handshake from the sequencer into the divider.
   typedef struct packed {
      logic             start;
      logic             neg;
      logic [WideW-1:0] num;
      logic [WideW-1:0] den;
   } div_req_type;
endpackage
`default_nettype wire

>>> sv/swlp_divider.sv
// ----------------------------------------------------------------------------
// swlp_divider
// Restoring divider, one quotient bit per cycle, rounds half away from zero
// and saturates to 24 bits signed.
// ----------------------------------------------------------------------------
`default_nettype none
module swlp_divider
   import swlp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire div_req_type               req,
   output logic                           done,
   output logic signed [SampleW-1:0]      quot
);
   localparam int CntW = $clog2(WideW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [WideW-1:0] a_ff, a_in;
   logic [WideW-1:0] b_ff, b_in;
   logic [WideW-1:0] r_ff, r_in;
   logic [WideW-1:0] q_ff, q_in;
   logic             neg_ff, neg_in;
   logic signed [SampleW-1:0] quot_ff, quot_in;
   logic [WideW:0]   rs;
   logic [WideW:0]   diff;
   logic [WideW-1:0] mag;
   logic [WideW-1:0] qn;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      mag     = req.neg ? (~req.num + 1'b1) : req.num;
      rs      = {r_ff, a_ff[WideW-1]};
      diff    = rs - {1'b0, b_ff};
      qn      = {q_ff[WideW-2:0], ~diff[WideW]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(WideW);
         a_in    = (mag << 1) + req.den;
         b_in    = req.den << 1;
         r_in    = '0;
         q_in    = '0;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         a_in   = a_ff << 1;
         r_in   = diff[WideW] ? rs[WideW-1:0] : diff[WideW-1:0];
         q_in   = qn;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff)
               quot_in = (qn > WideW'(24'd8388608)) ? -24'sd8388608
                         : SampleW'(~qn + 1'b1);
            else
               quot_in = (qn > WideW'(24'd8388607)) ? 24'sd8388607
                         : SampleW'(qn);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

>>> sv/swlp_ring.sv
// ----------------------------------------------------------------------------
// swlp_ring
// Slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module swlp_ring
   import swlp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [SlotW-1:0] wr_addr,
   input  wire slot_type         wr_data,
   input  wire logic [SlotW-1:0] rd_addr,
   output slot_type              rd_data
);
   slot_type mem [MaxSlots];
   slot_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

>>> sv/sliding_window_linear_predictor.sv
// ----------------------------------------------------------------------------
// sliding_window_linear_predictor
// Least-squares line fit over a ring of samples, predicts at timestamp + 1.
// ----------------------------------------------------------------------------
// A req transfer starts the slot pass; a fit then runs the products and the divider,
// equal valid times skip from Cxx to the divider, and a single valid sample goes out.
// Throughput: one item at a time; for a fit the slot pass (one read per cycle), seven
// 16-step 128-bit products and the 128-step divider set the time per item.
// The result register frees the core, so a new req transfer need not wait behind it.
// Reset (synchronous) clears valid bits and write pointer, window size = 5.
`default_nettype none
module sliding_window_linear_predictor
   import swlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // [23:0] sample, [55:24] timestamp
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [23:0] prediction
   output logic [1:0]       rsp_tuser,   // [1:0] status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // [4:0] window_size
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;   // issue reads / accumulate
   localparam logic [3:0] S_CXX   = 4'd2;   // Cxx = n*Sdd - Sd*Sd
   localparam logic [3:0] S_CXY   = 4'd3;   // Cxy = n*Sdy - Sd*Sy
   localparam logic [3:0] S_NUM0  = 4'd4;   // Sy*Cxx
   localparam logic [3:0] S_NUM1  = 4'd5;   // Cxy*(n - Sd)
   localparam logic [3:0] S_DEN   = 4'd6;   // n*Cxx
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_MULT  = 4'd9;   // shared 128x128 multiply loop

   // ---- state ------------------------------------------------------------
   logic [3:0]             st_ff, st_in;
   logic [3:0]             ret_ff, ret_in;       // state after multiply
   logic [WinW-1:0]        win_ff, win_in;
   logic [MaxSlots-1:0]    vld_ff, vld_in;
   logic [SlotW-1:0]       wp_ff, wp_in;
   logic [CountW-1:0]      idx_ff, idx_in;       // read issue index
   logic                   rdv_ff, rdv_in;       // read data is live
   logic [SlotW-1:0]       ridx_ff, ridx_in;     // slot of live read data
   logic signed [SampleW-1:0] y0_ff, y0_in;
   logic [TimeW-1:0]       t0_ff, t0_in;
   // Accumulators (sized generously; 128-bit two's complement math).
   logic [WideW-1:0]       sy_ff, sy_in;
   logic [WideW-1:0]       sd_ff, sd_in;
   logic [WideW-1:0]       sdy_ff, sdy_in;
   logic [WideW-1:0]       sdd_ff, sdd_in;
   logic [CountW-1:0]      n_ff, n_in;
   logic [WideW-1:0]       cxx_ff, cxx_in;
   logic [WideW-1:0]       cxy_ff, cxy_in;
   logic [WideW-1:0]       num_ff, num_in;
   logic [WideW-1:0]       tmp_ff, tmp_in;
   // Shared multiplier: 4x4 limbs of 32 bits, one partial product a cycle.
   logic [WideW-1:0]       ma_ff, ma_in;
   logic [WideW-1:0]       mb_ff, mb_in;
   logic [WideW-1:0]       mp_ff, mp_in;
   logic [3:0]             mk_ff, mk_in;
   logic [2:0]             ph_ff, ph_in;         // sub-step within a state
   logic [23:0]            pred_ff, pred_in;
   logic [1:0]             stat_ff, stat_in;
   // Result register, holds the transfer while the core takes the next item.
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]            rsp_pred_ff, rsp_pred_in;
   logic [1:0]             rsp_stat_ff, rsp_stat_in;

   // ---- effective window -------------------------------------------------
   logic [CountW-1:0] win_eff;
   always_comb begin
      if (win_ff == '0)
         win_eff = CountW'(1);
      else if (32'(win_ff) > MaxSlots)
         win_eff = CountW'(MaxSlots);
      else
         win_eff = CountW'(win_ff);
   end

   // ---- ring memory ------------------------------------------------------
   logic             mem_we;
   logic [SlotW-1:0] mem_wa;
   slot_type         mem_wd;
   slot_type         mem_rd;
   swlp_ring u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (idx_ff[SlotW-1:0]),
      .rd_data (mem_rd)
   );

   // ---- divider ----------------------------------------------------------
   div_req_type            dreq;
   logic                   ddone;
   logic signed [SampleW-1:0] dq;
   swlp_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .done  (ddone),
      .quot  (dq)
   );

   // ---- datapath helpers -------------------------------------------------
   logic signed [TimeW:0]   d_s;     // 33-bit signed time offset
   logic signed [56:0]      dy;
   logic [TimeW:0]          ad;
   logic [65:0]             ad2;
   logic [31:0]             la, lb;
   logic [63:0]             pp;
   logic [WideW-1:0]        pp_sh;
   logic [WideW-1:0]        wn;

   always_comb begin
      d_s   = $signed({1'b0, mem_rd.stamp}) - $signed({1'b0, t0_ff});
      dy    = 57'(d_s) * 57'(mem_rd.sample);
      ad    = d_s[TimeW] ? $unsigned(-d_s) : $unsigned(d_s);
      ad2   = 66'(ad) * 66'(ad);
      la    = ma_ff[32*mk_ff[3:2] +: 32];
      lb    = mb_ff[32*mk_ff[1:0] +: 32];
      pp    = 64'(la) * 64'(lb);
      pp_sh = WideW'(pp) << (32 * (7'(mk_ff[3:2]) + 7'(mk_ff[1:0])));
      wn    = WideW'(n_ff);
   end

   // A window write wins over a sample in the same cycle.
   assign req_tready = (st_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (st_ff == S_IDLE) && !rsp_tvalid_ff;

   always_comb begin
      st_in   = st_ff;   ret_in  = ret_ff;   win_in  = win_ff;
      vld_in  = vld_ff;  wp_in   = wp_ff;    idx_in  = idx_ff;
      rdv_in  = 1'b0;    ridx_in = idx_ff[SlotW-1:0];
      y0_in   = y0_ff;   t0_in   = t0_ff;
      sy_in   = sy_ff;   sd_in   = sd_ff;    sdy_in  = sdy_ff;
      sdd_in  = sdd_ff;  n_in    = n_ff;
      cxx_in  = cxx_ff;  cxy_in  = cxy_ff;   num_in  = num_ff;
      tmp_in  = tmp_ff;
      ma_in   = ma_ff;   mb_in   = mb_ff;    mp_in   = mp_ff;
      mk_in   = mk_ff;   ph_in   = ph_ff;
      pred_in = pred_ff; stat_in = stat_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_pred_in   = rsp_pred_ff;
      rsp_stat_in   = rsp_stat_ff;
      mem_we  = 1'b0;
      mem_wa  = wp_ff;
      mem_wd.sample = req_tdata[23:0];
      mem_wd.stamp  = req_tdata[55:24];
      dreq.start = 1'b0;
      dreq.neg   = 1'b0;
      dreq.num   = num_ff;
      dreq.den   = tmp_ff;

      if (rsp_tvalid_ff && rsp_tready)
         rsp_tvalid_in = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               win_in = csr_data[WinW-1:0];
               vld_in = '0;
               wp_in  = '0;
            end else if (req_tvalid && req_tready) begin
               // wrap pointer if window shrank below it
               mem_wa = (CountW'(wp_ff) >= win_eff) ? '0 : wp_ff;
               mem_we = 1'b1;
               vld_in[mem_wa] = 1'b1;
               wp_in  = (CountW'(mem_wa) + 1'b1 >= win_eff) ? '0
                        : SlotW'(CountW'(mem_wa) + 1'b1);
               y0_in  = req_tdata[23:0];
               t0_in  = req_tdata[55:24];
               sy_in = '0; sd_in = '0; sdy_in = '0; sdd_in = '0; n_in = '0;
               idx_in = '0;
               st_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            // read issued at idx, data arrives the next cycle
            if (rdv_ff && vld_ff[ridx_ff]) begin
               sy_in  = sy_ff + WideW'(mem_rd.sample);
               sd_in  = sd_ff + WideW'(d_s);
               sdy_in = sdy_ff + WideW'(dy);
               sdd_in = sdd_ff + WideW'(ad2);
               n_in   = n_ff + 1'b1;
            end
            if (idx_ff < win_eff) begin
               rdv_in  = 1'b1;
               ridx_in = idx_ff[SlotW-1:0];
               idx_in  = idx_ff + 1'b1;
            end else if (!rdv_ff) begin
               if (n_ff <= CountW'(1)) begin
                  pred_in = y0_ff;
                  stat_in = STATUS_SINGLE;
                  st_in   = S_OUT;
               end else begin
                  ph_in = '0;
                  st_in = S_CXX;
               end
            end
         end
         S_CXX: begin
            case (ph_ff)
               3'd0: begin ma_in = wn; mb_in = sdd_ff; mk_in = '0; mp_in = '0;
                  ret_in = S_CXX; ph_in = 3'd1; st_in = S_MULT; end
               3'd1: begin tmp_in = mp_ff; ma_in = sd_ff; mb_in = sd_ff;
                  mk_in = '0; mp_in = '0; ph_in = 3'd2; st_in = S_MULT; end
               default: begin
                  cxx_in = tmp_ff - mp_ff;
                  ph_in  = '0;
                  if (tmp_ff == mp_ff) begin
                     num_in = sy_ff;
                     tmp_in = wn;
                     st_in  = S_DIV;
                     stat_in = STATUS_MEAN;
                  end else begin
                     st_in = S_CXY;
                  end
               end
            endcase
         end
         S_CXY: begin
            case (ph_ff)
               3'd0: begin ma_in = wn; mb_in = sdy_ff; mk_in = '0; mp_in = '0;
                  ret_in = S_CXY; ph_in = 3'd1; st_in = S_MULT; end
               3'd1: begin tmp_in = mp_ff; ma_in = sd_ff; mb_in = sy_ff;
                  mk_in = '0; mp_in = '0; ph_in = 3'd2; st_in = S_MULT; end
               default: begin
                  cxy_in = tmp_ff - mp_ff; ph_in = '0; st_in = S_NUM0;
               end
            endcase
         end
         S_NUM0: begin
            ma_in = sy_ff; mb_in = cxx_ff; mk_in = '0; mp_in = '0;
            ret_in = S_NUM1; ph_in = '0; st_in = S_MULT;
         end
         S_NUM1: begin
            case (ph_ff)
               3'd0: begin num_in = mp_ff; ma_in = cxy_ff; mb_in = wn - sd_ff;
                  mk_in = '0; mp_in = '0; ph_in = 3'd1; st_in = S_MULT; end
               default: begin num_in = num_ff + mp_ff; ph_in = '0; st_in = S_DEN; end
            endcase
         end
         S_DEN: begin
            case (ph_ff)
               3'd0: begin ma_in = wn; mb_in = cxx_ff; mk_in = '0; mp_in = '0;
                  ret_in = S_DEN; ph_in = 3'd1; st_in = S_MULT; end
               default: begin
                  // den must be positive; fold sign of Cxx into numerator
                  if (mp_ff[WideW-1]) begin
                     tmp_in = ~mp_ff + 1'b1;
                     num_in = ~num_ff + 1'b1;
                  end else begin
                     tmp_in = mp_ff;
                  end
                  stat_in = STATUS_FIT;
                  ph_in   = '0;
                  st_in   = S_DIV;
               end
            endcase
         end
         S_DIV: begin
            if (ph_ff == '0) begin
               dreq.start = 1'b1;
               dreq.neg   = num_ff[WideW-1];
               ph_in      = 3'd1;
            end else if (ddone) begin
               pred_in = dq;
               st_in   = S_OUT;
            end
         end
         S_OUT: begin
            // wait here while the result register still holds a transfer
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_pred_in   = pred_ff;
               rsp_stat_in   = stat_ff;
               st_in         = S_IDLE;
            end
         end
         S_MULT: begin
            mp_in = mp_ff + pp_sh;
            mk_in = mk_ff + 1'b1;
            if (mk_ff == 4'd15)
               st_in = ret_ff;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         win_ff  <= WinReset;
         vld_ff  <= '0;
         wp_ff   <= '0;
         rdv_ff  <= 1'b0;
         ph_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         win_ff  <= win_in;
         vld_ff  <= vld_in;
         wp_ff   <= wp_in;
         rdv_ff  <= rdv_in;
         ph_ff   <= ph_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      ret_ff  <= ret_in;  idx_ff <= idx_in;  ridx_ff <= ridx_in;
      y0_ff   <= y0_in;   t0_ff  <= t0_in;
      sy_ff   <= sy_in;   sd_ff  <= sd_in;   sdy_ff <= sdy_in;
      sdd_ff  <= sdd_in;  n_ff   <= n_in;
      cxx_ff  <= cxx_in;  cxy_ff <= cxy_in;  num_ff <= num_in;
      tmp_ff  <= tmp_in;
      ma_ff   <= ma_in;   mb_ff  <= mb_in;   mp_ff  <= mp_in;
      mk_ff   <= mk_in;
      pred_ff <= pred_in; stat_ff <= stat_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_pred_ff;
   assign rsp_tuser  = rsp_stat_ff;
endmodule
`default_nettype wire

>>> sim/swlp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swlp_checker
// Watches the predictor's channels, models the least-squares fit over the
// sample ring and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module swlp_checker
   import swlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [7:0]  csr_data,
   output int               errors,
   output int               pending,
   output int               checked
);
   typedef logic signed [WideW-1:0] wide_type;
   typedef struct {
      logic [23:0] pred;
      logic [1:0]  status;
   } fit_result_type;

   fit_result_type        fit_queue[$];
   logic signed [23:0]    ring_sample[MaxSlots];
   logic [31:0]           ring_stamp[MaxSlots];
   logic                  ring_used[MaxSlots];
   int                    ring_ptr;
   logic [4:0]            win_reg;

   function automatic logic [23:0] round_sat(wide_type num, wide_type den);
      logic          neg;
      logic [127:0]  mag;
      logic [127:0]  q;
      neg = num[127];
      mag = neg ? -num : num;
      q = (mag * 2 + den) / (den * 2);
      if (neg) return (q > 128'd8388608) ? 24'h800000 : 24'(-q);
      return (q > 128'd8388607) ? 24'h7FFFFF : 24'(q);
   endfunction

   function automatic fit_result_type fit_line(logic signed [23:0] y0, logic [31:0] t0);
      fit_result_type r;
      int          win;
      int          n;
      longint      sy, sd, sdy, d;
      wide_type    sdd, cxx, cxy, num, wn;
      win = (win_reg < 1) ? 1 : (win_reg > MaxSlots) ? MaxSlots : int'(win_reg);
      if (ring_ptr >= win) ring_ptr = 0;
      ring_sample[ring_ptr] = y0;
      ring_stamp[ring_ptr] = t0;
      ring_used[ring_ptr] = 1'b1;
      ring_ptr = (ring_ptr + 1) % win;
      sy = 0; sd = 0; sdy = 0; sdd = 0; n = 0;
      for (int i = 0; i < win; i++) begin
         if (ring_used[i]) begin
            d = longint'({32'b0, ring_stamp[i]}) - longint'({32'b0, t0});
            sy += longint'(ring_sample[i]);
            sd += d;
            sdy += d * longint'(ring_sample[i]);
            sdd += wide_type'(d) * wide_type'(d);
            n++;
         end
      end
      if (n <= 1) begin
         r.pred = y0;
         r.status = STATUS_SINGLE;
      end else begin
         wn = n;
         cxx = wn * sdd - wide_type'(sd) * wide_type'(sd);
         if (cxx == 0) begin
            r.pred = round_sat(wide_type'(sy), wn);
            r.status = STATUS_MEAN;
         end else begin
            cxy = wn * wide_type'(sdy) - wide_type'(sd) * wide_type'(sy);
            num = wide_type'(sy) * cxx + cxy * (wn - wide_type'(sd));
            r.pred = round_sat(num, wn * cxx);
            r.status = STATUS_FIT;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      fit_result_type exp_r;
      if (reset) begin
         fit_queue.delete();
         foreach (ring_used[i]) ring_used[i] = 1'b0;
         ring_ptr = 0;
         win_reg = WinReset;
         errors = 0;
         checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            win_reg = csr_data[4:0];
            foreach (ring_used[i]) ring_used[i] = 1'b0;
            ring_ptr = 0;
         end
         if (req_tvalid && req_tready)
            fit_queue.push_back(fit_line(req_tdata[23:0], req_tdata[55:24]));
         if (rsp_tvalid && rsp_tready) begin
            if (fit_queue.size() == 0) begin
               $display("%0t: unexpected result pred=%h status=%0d",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               exp_r = fit_queue.pop_front();
               checked++;
               if (rsp_tdata !== exp_r.pred || rsp_tuser !== exp_r.status) begin
                  $display("%0t: mismatch expected pred=%h status=%0d, got pred=%h status=%0d",
                           $time, exp_r.pred, exp_r.status, rsp_tdata, rsp_tuser);
                  errors++;
               end
            end
         end
      end
      pending = fit_queue.size();
   end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples through the sliding-window predictor over a series of
// window sizes and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import swlp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // [23:0] sample, [55:24] timestamp
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [23:0] prediction
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;    // [4:0] window_size

   int          errors, pending, checked;
   int          sent;
   int          send_idle_pct;   // sender gap chance per cycle
   int          stall_pct;       // receiver stall chance per cycle
   logic        hold_rsp;        // request a long receiver hold-off
   logic [31:0] stamp_now;

   sliding_window_linear_predictor u_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_data
   );

   swlp_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_data,
      .errors, .pending, .checked
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Receiver: random stalls, plus a long hold-off on request so the block
   // backs up and stalls its input.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (1500) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // One input transfer; gaps come before the item, valid stays up between
   // back-to-back items.
   task automatic send_sample(logic [23:0] y, logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, y};
      do @(posedge clock); while (!req_tready);
      sent++;
      @(negedge clock);
   endtask

   // Window size write, only once all results are back.
   task automatic write_window(logic [7:0] value);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (300) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly a rising time line with small steps; sometimes repeats, far
   // jumps and the top of the time range.
   task automatic send_random;
      logic [23:0] y;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10)      stamp_now = $urandom;
      else if (pick < 14) stamp_now = 32'hFFFF_FFFF - $urandom_range(3);
      else if (pick < 30) stamp_now = stamp_now;
      else                stamp_now = stamp_now + $urandom_range(1, 8);
      pick = $urandom_range(99);
      if (pick < 40)      y = 24'($urandom);
      else if (pick < 45) y = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      else                y = 24'($signed($urandom_range(2000)) - 1000);
      send_sample(y, stamp_now);
   endtask

   initial begin
      logic [4:0] windows[10];
      windows = '{5'd5, 5'd1, 5'd16, 5'd0, 5'd31, 5'd17,
                  5'd3, 5'd8, 5'd2, 5'd12};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_rsp = 1'b0;
      sent = 0;
      stamp_now = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: single sample, equal times (mean), time wrap edge,
      // saturation both ways, plain fits.
      send_sample(24'h7FFFFF, 32'd0);
      send_sample(24'h800000, 32'd0);
      send_sample(24'h000001, 32'd0);
      send_sample(24'h800000, 32'd1);
      send_sample(24'h7FFFFF, 32'd2);
      send_sample(24'h7FFFFF, 32'd3);
      send_sample(24'h000000, 32'hFFFF_FFFE);
      send_sample(24'h000064, 32'hFFFF_FFFF);
      send_sample(24'hFFFFFF, 32'hFFFF_FFFF);
      send_sample(24'h555555, 32'hAAAA_AAAA);
      send_sample(24'hAAAAAA, 32'h5555_5555);
      send_sample(24'h000010, 32'd100);
      send_sample(24'h000020, 32'd101);
      send_sample(24'h000031, 32'd102);

      for (int ph = 0; ph < 10; ph++) begin
         if (ph > 0) write_window({3'($urandom), windows[ph]});
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         for (int k = 0; k < 43; k++) begin
            if (ph == 2 && k == 10) hold_rsp = 1'b1;
            if (ph == 5 && k == 20) begin
               req_tvalid <= 1'b0;
               wait (pending == 0);
               @(negedge clock);
            end
            send_random();
         end
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (300) @(negedge clock);
      $display("Sent %0d samples over 10 window sizes (0, 1, 16 and above 16 included),",
               sent);
      $display("checked %0d predictions under four idle patterns.", checked);
      if (errors == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

>>> sim.f
sv/swlp_pkg.sv
sv/swlp_divider.sv
sv/swlp_ring.sv
sv/sliding_window_linear_predictor.sv
sim/swlp_checker.sv
sim/testbench.sv
